// File: src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Phase codes, result kinds, the queued result record and the UTF-8 encoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // decoder phase
    typedef enum logic [3:0] {
        PH_OPEN  = 4'd0,
        PH_BODY  = 4'd1,
        PH_ESC   = 4'd2,
        PH_HEX1  = 4'd3,
        PH_BSL   = 4'd4,
        PH_LOWU  = 4'd5,
        PH_HEX2  = 4'd6,
        PH_DONE  = 4'd7,
        PH_ERROR = 4'd8
    } t_phase;

    // result kind
    typedef enum logic [1:0] {
        K_BYTE     = 2'd0,
        K_COMPLETE = 2'd1,
        K_ILLEGAL  = 2'd2,
        K_UNCLOSED = 2'd3
    } t_kind;

    // results caused by one input item: one to four, byte 0 first
    typedef struct packed {
        t_kind           kind;
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } t_rec;

    // characters of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_UP_U   = 8'h55;

    // surrogate ranges and code point limits
    localparam logic [15:0] SURR_HIGH_MIN = 16'hD800;
    localparam logic [15:0] SURR_LOW_MIN  = 16'hDC00;
    localparam logic [15:0] SURR_MAX      = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;
    localparam logic [20:0] CP_MAX1       = 21'h7F;
    localparam logic [20:0] CP_MAX2       = 21'h7FF;
    localparam logic [20:0] CP_MAX3       = 21'hFFFF;

    // utf-8 lead and continuation bytes
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;
    localparam logic [7:0] UTF8_MASK6 = 8'h3F;

    // single result record
    function automatic t_rec mk_rec(t_kind kind, logic [7:0] b);
        t_rec r;
        r.kind     = kind;
        r.last_idx = 2'd0;
        r.bytes    = '0;
        r.bytes[0] = (kind == K_BYTE) ? b : 8'h00;
        return r;
    endfunction

    // hex digit value, bit 4 set for a non-hex character
    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            v = {1'b0, c[3:0] + 4'd9};
        return v;
    endfunction

    // utf-8 encoding of one code point into a record of one to four bytes
    function automatic t_rec utf8_rec(logic [20:0] cp);
        t_rec r;
        r.kind  = K_BYTE;
        r.bytes = '0;
        if (cp <= CP_MAX1) begin
            r.last_idx = 2'd0;
            r.bytes[0] = cp[7:0];
        end else if (cp <= CP_MAX2) begin
            r.last_idx = 2'd1;
            r.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
            r.bytes[1] = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK6);
        end else if (cp <= CP_MAX3) begin
            r.last_idx = 2'd2;
            r.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
            r.bytes[1] = UTF8_CONT | ({2'b00, cp[11:6]} & UTF8_MASK6);
            r.bytes[2] = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK6);
        end else begin
            r.last_idx = 2'd3;
            r.bytes[0] = UTF8_LEAD4 | {5'b00000, cp[20:18]};
            r.bytes[1] = UTF8_CONT | ({2'b00, cp[17:12]} & UTF8_MASK6);
            r.bytes[2] = UTF8_CONT | ({2'b00, cp[11:6]} & UTF8_MASK6);
            r.bytes[3] = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK6);
        end
        return r;
    endfunction

endpackage

// File: src/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_if: stream interfaces of the JSON string unescaper
// Input channel carries raw text bytes, output channel carries results.
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_data;

    modport source (output valid, output text_byte, output end_of_data, input ready);
    modport sink   (input valid, input text_byte, input end_of_data, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output kind, output data_byte, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input last, output ready);
endinterface

// File: src/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string literal unescaper with UTF-8 output
// Decodes escapes and \u sequences of one quoted string into result items.
// ----------------------------------------------------------------------------
//   channel  dir  payload                         accepted when
//   i_in     in   text_byte, end_of_data          valid && ready
//   o_out    out  kind, data_byte, last           valid && ready
//
// One text item is taken every cycle while the record queue has room.
// Each item causes zero to four results; the emitter sends one result a
// cycle when ready, so items expanding to several bytes set the output rate.
// Synchronous active-low reset returns to awaiting the opening quote.
// Output stalls back up into the queue and then drop input ready.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

    logic          push, full, pop, empty;
    jsu_pkg::t_rec push_rec, head_rec;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_rec   (push_rec)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head_rec)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head_rec),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// File: src/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front: escape decoder
// Accepts one text item a cycle while the queue has room, tracks the escape
// phase and pushes one record per item that causes results.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jsu_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output jsu_pkg::t_rec o_rec
);

    jsu_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_acc, n_acc;
    logic [1:0]      r_cnt, n_cnt;
    logic [9:0]      r_hs, n_hs;

    logic        accept;
    logic [7:0]  c;
    logic [4:0]  hv;
    logic [15:0] cp16;
    logic [20:0] cp_pair;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign c          = i_in.text_byte;
    assign hv         = jsu_pkg::hex_value(c);
    assign cp16       = {r_acc[11:0], hv[3:0]};
    assign cp_pair    = jsu_pkg::SUPP_BASE + {1'b0, r_hs, 10'b0}
                      + {11'b0, cp16[9:0]};

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jsu_pkg::PH_OPEN;
            r_cnt   <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    // hex digits and surrogate half
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 16'h0000;
            r_hs  <= 10'h000;
        end else begin
            r_acc <= n_acc;
            r_hs  <= n_hs;
        end
    end

    // next phase and record to queue
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_hs    = r_hs;
        o_push  = 1'b0;
        o_rec   = jsu_pkg::mk_rec(jsu_pkg::K_BYTE, 8'h00);
        if (accept) begin
            if (i_in.end_of_data) begin
                n_phase = jsu_pkg::PH_OPEN;
                n_acc   = 16'h0000;
                n_cnt   = 2'd0;
                n_hs    = 10'h000;
                case (r_phase)
                    jsu_pkg::PH_OPEN, jsu_pkg::PH_BODY, jsu_pkg::PH_ESC: begin
                        o_push = 1'b1;
                        o_rec  = jsu_pkg::mk_rec(jsu_pkg::K_UNCLOSED, 8'h00);
                    end
                    jsu_pkg::PH_HEX1, jsu_pkg::PH_BSL, jsu_pkg::PH_LOWU,
                    jsu_pkg::PH_HEX2: begin
                        o_push = 1'b1;
                        o_rec  = jsu_pkg::mk_rec(jsu_pkg::K_ILLEGAL, 8'h00);
                    end
                    default: begin
                    end
                endcase
            end else begin
                case (r_phase)
                    jsu_pkg::PH_OPEN: n_phase = jsu_pkg::PH_BODY;
                    jsu_pkg::PH_BODY: begin
                        case (c)
                            jsu_pkg::CH_QUOTE: begin
                                o_push  = 1'b1;
                                o_rec   = jsu_pkg::mk_rec(jsu_pkg::K_COMPLETE, 8'h00);
                                n_phase = jsu_pkg::PH_DONE;
                            end
                            jsu_pkg::CH_TAB, jsu_pkg::CH_LF, jsu_pkg::CH_FF,
                            jsu_pkg::CH_BS, jsu_pkg::CH_CR: begin
                                o_push  = 1'b1;
                                o_rec   = jsu_pkg::mk_rec(jsu_pkg::K_ILLEGAL, 8'h00);
                                n_phase = jsu_pkg::PH_ERROR;
                            end
                            jsu_pkg::CH_BSLASH: n_phase = jsu_pkg::PH_ESC;
                            default: begin
                                o_push = 1'b1;
                                o_rec  = jsu_pkg::mk_rec(jsu_pkg::K_BYTE, c);
                            end
                        endcase
                    end
                    jsu_pkg::PH_ESC: begin
                        n_phase = jsu_pkg::PH_BODY;
                        o_push  = 1'b1;
                        case (c)
                            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
                                o_rec = jsu_pkg::mk_rec(jsu_pkg::K_BYTE, c);
                            jsu_pkg::CH_N: o_rec = jsu_pkg::mk_rec(jsu_pkg::K_BYTE, jsu_pkg::CH_LF);
                            jsu_pkg::CH_R: o_rec = jsu_pkg::mk_rec(jsu_pkg::K_BYTE, jsu_pkg::CH_CR);
                            jsu_pkg::CH_T: o_rec = jsu_pkg::mk_rec(jsu_pkg::K_BYTE, jsu_pkg::CH_TAB);
                            jsu_pkg::CH_F: o_rec = jsu_pkg::mk_rec(jsu_pkg::K_BYTE, jsu_pkg::CH_FF);
                            jsu_pkg::CH_B: o_rec = jsu_pkg::mk_rec(jsu_pkg::K_BYTE, jsu_pkg::CH_BS);
                            jsu_pkg::CH_LO_U, jsu_pkg::CH_UP_U: begin
                                o_push  = 1'b0;
                                n_phase = jsu_pkg::PH_HEX1;
                                n_acc   = 16'h0000;
                                n_cnt   = 2'd0;
                            end
                            default: begin
                                o_rec   = jsu_pkg::mk_rec(jsu_pkg::K_ILLEGAL, 8'h00);
                                n_phase = jsu_pkg::PH_ERROR;
                            end
                        endcase
                    end
                    jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                        if (hv[4]) begin
                            o_push  = 1'b1;
                            o_rec   = jsu_pkg::mk_rec(jsu_pkg::K_ILLEGAL, 8'h00);
                            n_phase = jsu_pkg::PH_ERROR;
                        end else begin
                            n_acc = cp16;
                            if (r_cnt != 2'd3) begin
                                n_cnt = r_cnt + 2'd1;
                            end else begin
                                n_cnt = 2'd0;
                                if (r_phase == jsu_pkg::PH_HEX1) begin
                                    if (cp16 >= jsu_pkg::SURR_HIGH_MIN
                                            && cp16 <= jsu_pkg::SURR_MAX) begin
                                        if (cp16 >= jsu_pkg::SURR_LOW_MIN) begin
                                            o_push  = 1'b1;
                                            o_rec   = jsu_pkg::mk_rec(jsu_pkg::K_ILLEGAL, 8'h00);
                                            n_phase = jsu_pkg::PH_ERROR;
                                        end else begin
                                            n_hs    = cp16[9:0];
                                            n_phase = jsu_pkg::PH_BSL;
                                        end
                                    end else begin
                                        o_push  = 1'b1;
                                        o_rec   = jsu_pkg::utf8_rec({5'b00000, cp16});
                                        n_phase = jsu_pkg::PH_BODY;
                                    end
                                end else begin
                                    o_push = 1'b1;
                                    if (cp16 < jsu_pkg::SURR_LOW_MIN
                                            || cp16 > jsu_pkg::SURR_MAX) begin
                                        o_rec   = jsu_pkg::mk_rec(jsu_pkg::K_ILLEGAL, 8'h00);
                                        n_phase = jsu_pkg::PH_ERROR;
                                    end else begin
                                        o_rec   = jsu_pkg::utf8_rec(cp_pair);
                                        n_phase = jsu_pkg::PH_BODY;
                                    end
                                end
                            end
                        end
                    end
                    jsu_pkg::PH_BSL: begin
                        if (c == jsu_pkg::CH_BSLASH) begin
                            n_phase = jsu_pkg::PH_LOWU;
                        end else begin
                            o_push  = 1'b1;
                            o_rec   = jsu_pkg::mk_rec(jsu_pkg::K_ILLEGAL, 8'h00);
                            n_phase = jsu_pkg::PH_ERROR;
                        end
                    end
                    jsu_pkg::PH_LOWU: begin
                        if (c == jsu_pkg::CH_LO_U) begin
                            n_phase = jsu_pkg::PH_HEX2;
                            n_acc   = 16'h0000;
                            n_cnt   = 2'd0;
                        end else begin
                            o_push  = 1'b1;
                            o_rec   = jsu_pkg::mk_rec(jsu_pkg::K_ILLEGAL, 8'h00);
                            n_phase = jsu_pkg::PH_ERROR;
                        end
                    end
                    jsu_pkg::PH_DONE, jsu_pkg::PH_ERROR: begin
                    end
                    default: n_phase = jsu_pkg::PH_ERROR;
                endcase
            end
        end
    end

    // a status record always carries a single result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_rec.kind != jsu_pkg::K_BYTE |-> o_rec.last_idx == 2'd0)
        else $error("status record with more than one result");

    // no result is caused before the opening quote except by end of data
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && r_phase == jsu_pkg::PH_OPEN |-> i_in.end_of_data)
        else $error("result pushed for the opening quote");

endmodule

// File: src/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue: record queue between decoder and result emitter
// Small register fifo, one push and one pop a cycle.
// ----------------------------------------------------------------------------
module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_rec i_rec,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output jsu_pkg::t_rec o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::t_rec r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_rec;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push)
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            if (i_pop)
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            if (i_push && !i_pop)
                r_count <= r_count + CW'(1);
            else if (!i_push && i_pop)
                r_count <= r_count - CW'(1);
        end
    end

    // no overflow or underflow
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_full |-> !i_push)
        else $error("push into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

// File: src/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back: result emitter
// Walks the head record bytes, one result a cycle when ready, marks the last.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  jsu_pkg::t_rec i_head,
    output logic          o_pop,
    jsu_out_if.source     o_out
);

    logic [1:0] r_idx;
    logic       fire;
    logic       at_last;

    assign at_last         = (r_idx == i_head.last_idx);
    assign fire            = o_out.valid && o_out.ready;
    assign o_pop           = fire && at_last;
    assign o_out.valid     = !i_empty;
    assign o_out.kind      = i_head.kind;
    assign o_out.data_byte = i_head.bytes[r_idx];
    assign o_out.last      = at_last;

    // byte position within the head record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (fire) begin
            r_idx <= at_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    // position never runs past the record's last byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> r_idx <= i_head.last_idx)
        else $error("byte position beyond record");

endmodule
